// ===== rtl/core/bfra_pkg.sv =====
// Shared constants and control types for the best-fit region allocator.
`default_nettype none
package bfra_pkg;
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ADDR_BITS_DEF   = 20;

	localparam logic       CMD_ALLOC   = 1'b0;
	localparam logic       CMD_RELEASE = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_NOOWNER = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	// write data selection for the region table
	localparam logic [2:0] W_INIT   = 3'd0;
	localparam logic [2:0] W_COPY   = 3'd1;
	localparam logic [2:0] W_HEAD   = 3'd2;
	localparam logic [2:0] W_TAIL   = 3'd3;
	localparam logic [2:0] W_MPREV1 = 3'd4;
	localparam logic [2:0] W_MPREV2 = 3'd5;
	localparam logic [2:0] W_MNEXT  = 3'd6;
	localparam logic [2:0] W_FREE   = 3'd7;

	typedef struct packed {
		logic       rd_en;
		logic       wr_en;
		logic [2:0] wsel;
		logic       ev;
		logic       cap_next;
		logic       ld_req;
		logic       init_done;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       cnt_dec2;
		logic       out_ld;
		logic [1:0] out_status;
	} dp_cmd_t;

	typedef struct packed {
		logic init_pend;
		logic cmd_rel;
		logic hit;
		logic found;
		logic zreq;
		logic split;
		logic full;
		logic prev_free;
		logic next_free;
		logic out_busy;
	} dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/bfra_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface bfra_req_if #(parameter int AB = 20);
	logic          valid;
	logic          ready;
	logic          command;
	logic [15:0]   owner_id;
	logic [AB-1:0] request_size;
	modport source (output valid, command, owner_id, request_size, input ready);
	modport sink (input valid, command, owner_id, request_size, output ready);
endinterface

interface bfra_rsp_if #(parameter int AB = 20);
	logic          valid;
	logic          ready;
	logic [1:0]    result_status;
	logic [AB-1:0] region_start;
	logic [AB-1:0] region_length;
	modport source (output valid, result_status, region_start, region_length, input ready);
	modport sink (input valid, result_status, region_start, region_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bfra_datapath.sv =====
// Region table memory, scan compare, merge arithmetic and result register.
`default_nettype none
module bfra_datapath #(
	parameter int TABLE_DEPTH = 64,
	parameter int ADDR_BITS   = 20,
	parameter int AW          = 6,
	parameter int CW          = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_BITS-1:0] cfg_wdata,
	input  wire logic              req_command,
	input  wire logic [15:0]       req_owner,
	input  wire logic [ADDR_BITS-1:0] req_size,
	input  wire bfra_pkg::dp_cmd_t cmd,
	input  wire logic [AW-1:0]     rd_addr,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [AW-1:0]     ev_idx,
	output logic [AW-1:0]          best_idx,
	output logic [CW-1:0]          count,
	output bfra_pkg::dp_sts_t      sts,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [1:0]             out_status,
	output logic [ADDR_BITS-1:0]   out_start,
	output logic [ADDR_BITS-1:0]   out_length
);
	import bfra_pkg::*;

	logic [ADDR_BITS-1:0] mem_start [TABLE_DEPTH];
	logic [ADDR_BITS-1:0] mem_len   [TABLE_DEPTH];
	logic [15:0]          mem_own   [TABLE_DEPTH];
	logic                 mem_free  [TABLE_DEPTH];

	logic [ADDR_BITS-1:0] rd_start_q, rd_len_q;
	logic [15:0]          rd_own_q;
	logic                 rd_free_q;

	logic [ADDR_BITS-1:0] tot_q, req_q;
	logic [15:0]          own_q;
	logic                 rel_q, init_pend_q;
	logic [CW-1:0]        count_q;

	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	logic [ADDR_BITS-1:0] best_len_q, best_start_q;
	logic [ADDR_BITS-1:0] hit_start_q, hit_len_q, prev_start_q, prev_len_q, next_len_q;
	logic                 prev_free_q, next_free_q;

	logic                 out_v_q;
	logic [1:0]           out_st_q;
	logic [ADDR_BITS-1:0] out_start_q, out_len_q;

	logic                 match, better;
	logic [ADDR_BITS-1:0] w_start, w_len;
	logic [15:0]          w_own;
	logic                 w_free;

	assign match  = !rd_free_q && (rd_own_q == own_q);
	assign better = rd_free_q && (rd_len_q >= req_q) && (!found_q || rd_len_q < best_len_q);

	always_comb begin
		w_start = rd_start_q;
		w_len   = rd_len_q;
		w_own   = rd_own_q;
		w_free  = rd_free_q;
		case (cmd.wsel)
			W_INIT: begin
				w_start = '0; w_len = tot_q; w_own = '0; w_free = 1'b1;
			end
			W_COPY: begin
			end
			W_HEAD: begin
				w_start = best_start_q; w_len = req_q; w_own = own_q; w_free = 1'b0;
			end
			W_TAIL: begin
				w_start = best_start_q + req_q; w_len = best_len_q - req_q;
				w_own = '0; w_free = 1'b1;
			end
			W_MPREV1: begin
				w_start = prev_start_q; w_len = prev_len_q + hit_len_q;
				w_own = '0; w_free = 1'b1;
			end
			W_MPREV2: begin
				w_start = prev_start_q; w_len = prev_len_q + hit_len_q + next_len_q;
				w_own = '0; w_free = 1'b1;
			end
			W_MNEXT: begin
				w_start = hit_start_q; w_len = hit_len_q + next_len_q;
				w_own = '0; w_free = 1'b1;
			end
			W_FREE: begin
				w_start = hit_start_q; w_len = hit_len_q; w_own = '0; w_free = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_start[wr_addr] <= w_start;
			mem_len[wr_addr]   <= w_len;
			mem_own[wr_addr]   <= w_own;
			mem_free[wr_addr]  <= w_free;
		end
		if (cmd.rd_en) begin
			rd_start_q <= mem_start[rd_addr];
			rd_len_q   <= mem_len[rd_addr];
			rd_own_q   <= mem_own[rd_addr];
			rd_free_q  <= mem_free[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q       <= '1;
			init_pend_q <= 1'b1;
			count_q     <= '0;
			found_q     <= 1'b0;
			prev_free_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cmd.init_done) begin
				init_pend_q <= 1'b0;
				count_q     <= (tot_q != '0) ? CW'(1) : '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - (cmd.cnt_dec2 ? CW'(2) : CW'(1));
			end
			if (cfg_we) begin
				tot_q       <= cfg_wdata;
				init_pend_q <= 1'b1;
			end
			if (cmd.ld_req) begin
				found_q     <= 1'b0;
				prev_free_q <= 1'b0;
			end else if (cmd.ev) begin
				if (!rel_q && better)
					found_q <= 1'b1;
				if (rel_q && !match)
					prev_free_q <= rd_free_q;
			end
			if (cmd.out_ld)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			req_q <= req_size;
			own_q <= req_owner;
			rel_q <= req_command;
		end
		if (cmd.ev) begin
			if (!rel_q && better) begin
				best_idx_q   <= ev_idx;
				best_len_q   <= rd_len_q;
				best_start_q <= rd_start_q;
			end
			if (rel_q && match) begin
				hit_start_q <= rd_start_q;
				hit_len_q   <= rd_len_q;
			end else begin
				prev_start_q <= rd_start_q;
				prev_len_q   <= rd_len_q;
			end
		end
		if (cmd.cap_next) begin
			next_len_q  <= rd_len_q;
			next_free_q <= rd_free_q;
		end
		if (cmd.out_ld) begin
			out_st_q <= cmd.out_status;
			if (cmd.out_status != ST_OK) begin
				out_start_q <= '0;
				out_len_q   <= '0;
			end else if (rel_q) begin
				out_start_q <= hit_start_q;
				out_len_q   <= hit_len_q;
			end else begin
				out_start_q <= best_start_q;
				out_len_q   <= req_q;
			end
		end
	end

	always_comb begin
		sts.init_pend = init_pend_q;
		sts.cmd_rel   = rel_q;
		sts.hit       = cmd.ev && rel_q && match;
		sts.found     = found_q;
		sts.zreq      = (req_q == '0);
		sts.split     = best_len_q > req_q;
		sts.full      = count_q >= CW'(TABLE_DEPTH);
		sts.prev_free = prev_free_q;
		sts.next_free = next_free_q;
		sts.out_busy  = out_v_q && !out_ready;
	end

	assign best_idx   = best_idx_q;
	assign count      = count_q;
	assign out_valid  = out_v_q;
	assign out_status = out_st_q;
	assign out_start  = out_start_q;
	assign out_length = out_len_q;
endmodule
`default_nettype wire

// ===== rtl/core/bfra_ctrl.sv =====
// Sequencer: table scan, shift passes, split and merge writes.
`default_nettype none
module bfra_ctrl #(
	parameter int AW = 6,
	parameter int CW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire bfra_pkg::dp_sts_t sts,
	input  wire logic [AW-1:0]     best_idx,
	input  wire logic [CW-1:0]     count,
	output bfra_pkg::dp_cmd_t      cmd,
	output logic [AW-1:0]          rd_addr,
	output logic [AW-1:0]          wr_addr,
	output logic [AW-1:0]          ev_idx
);
	import bfra_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_SCAN = 4'd2;
	localparam logic [3:0] S_ADEC = 4'd3;
	localparam logic [3:0] S_UP   = 4'd4;
	localparam logic [3:0] S_TAIL = 4'd5;
	localparam logic [3:0] S_HEAD = 4'd6;
	localparam logic [3:0] S_RNX  = 4'd7;
	localparam logic [3:0] S_RNX2 = 4'd8;
	localparam logic [3:0] S_RWR  = 4'd9;
	localparam logic [3:0] S_DN   = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] ri_q, ri_d, lo_q, lo_d, hit_q, hit_d;
	logic          ev_v_q, ev_v_d, pend_v_q, pend_v_d, dist2_q, dist2_d;
	logic [AW-1:0] ev_idx_q, ev_idx_d, pend_dst_q, pend_dst_d;
	logic [1:0]    st_q, st_d;
	logic          cinc_q, cinc_d, cdec_q, cdec_d;
	logic          issue, pm, nm;
	logic [CW-1:0] best_w, dist_w;

	assign best_w = CW'(best_idx);
	assign dist_w = dist2_q ? CW'(2) : CW'(1);
	assign pm     = (hit_q != '0) && sts.prev_free;
	assign nm     = (hit_q + CW'(1) < count) && sts.next_free;
	assign ev_idx = ev_idx_q;
	assign req_ready = (state_q == S_IDLE) && !sts.init_pend;

	always_comb begin
		state_d = state_q; ri_d = ri_q; lo_d = lo_q; hit_d = hit_q;
		ev_v_d = 1'b0; ev_idx_d = ev_idx_q; pend_v_d = 1'b0; pend_dst_d = pend_dst_q;
		dist2_d = dist2_q; st_d = st_q; cinc_d = cinc_q; cdec_d = cdec_q;
		cmd = '0;
		cmd.wsel = W_COPY;
		rd_addr = ri_q[AW-1:0];
		wr_addr = pend_dst_q;
		issue = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (sts.init_pend) begin
					state_d = S_INIT;
				end else if (req_valid) begin
					cmd.ld_req = 1'b1;
					ri_d = '0; cinc_d = 1'b0; cdec_d = 1'b0; dist2_d = 1'b0;
					state_d = S_SCAN;
				end
			end
			S_INIT: begin
				cmd.wr_en = 1'b1; cmd.wsel = W_INIT; cmd.init_done = 1'b1;
				wr_addr = '0;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				issue = ri_q < count;
				cmd.rd_en = issue;
				cmd.ev = ev_v_q;
				if (sts.hit) begin
					hit_d = CW'(ev_idx_q);
					state_d = S_RNX;
				end else if (!issue && !ev_v_q) begin
					if (sts.cmd_rel) begin
						st_d = ST_NOOWNER; state_d = S_DONE;
					end else begin
						state_d = S_ADEC;
					end
				end else begin
					ri_d = ri_q + CW'(issue);
					ev_v_d = issue;
					ev_idx_d = ri_q[AW-1:0];
				end
			end
			S_ADEC: begin
				if (sts.zreq || !sts.found) begin
					st_d = ST_NOFIT; state_d = S_DONE;
				end else if (sts.split && sts.full) begin
					st_d = ST_FULL; state_d = S_DONE;
				end else if (sts.split) begin
					ri_d = count - CW'(1);
					lo_d = best_w + CW'(1);
					cinc_d = 1'b1;
					state_d = S_UP;
				end else begin
					state_d = S_HEAD;
				end
			end
			S_UP: begin
				// entries above the split move up by one; the index stops at the bound
				issue = ri_q >= lo_q;
				cmd.rd_en = issue;
				cmd.wr_en = pend_v_q;
				pend_v_d = issue;
				pend_dst_d = ri_q[AW-1:0] + AW'(1);
				ri_d = ri_q - CW'(issue);
				if (!issue && !pend_v_q)
					state_d = S_TAIL;
			end
			S_TAIL: begin
				cmd.wr_en = 1'b1; cmd.wsel = W_TAIL;
				wr_addr = best_idx + AW'(1);
				state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.wr_en = 1'b1; cmd.wsel = W_HEAD;
				wr_addr = best_idx;
				st_d = ST_OK; state_d = S_DONE;
			end
			S_RNX: begin
				rd_addr = hit_q[AW-1:0] + AW'(1);
				if (hit_q + CW'(1) < count) begin
					cmd.rd_en = 1'b1; state_d = S_RNX2;
				end else begin
					state_d = S_RWR;
				end
			end
			S_RNX2: begin
				cmd.cap_next = 1'b1;
				state_d = S_RWR;
			end
			S_RWR: begin
				cmd.wr_en = 1'b1;
				st_d = ST_OK;
				if (pm) begin
					wr_addr = hit_q[AW-1:0] - AW'(1);
					cmd.wsel = nm ? W_MPREV2 : W_MPREV1;
					dist2_d = nm; cdec_d = 1'b1;
					ri_d = hit_q + (nm ? CW'(2) : CW'(1));
					state_d = S_DN;
				end else if (nm) begin
					wr_addr = hit_q[AW-1:0];
					cmd.wsel = W_MNEXT;
					dist2_d = 1'b0; cdec_d = 1'b1;
					ri_d = hit_q + CW'(2);
					state_d = S_DN;
				end else begin
					wr_addr = hit_q[AW-1:0];
					cmd.wsel = W_FREE;
					state_d = S_DONE;
				end
			end
			S_DN: begin
				// close the gap left by merged entries
				issue = ri_q < count;
				cmd.rd_en = issue;
				cmd.wr_en = pend_v_q;
				pend_v_d = issue;
				pend_dst_d = ri_q[AW-1:0] - dist_w[AW-1:0];
				ri_d = ri_q + CW'(1);
				if (!issue && !pend_v_q)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					cmd.out_status = st_q;
					cmd.cnt_inc = cinc_q;
					cmd.cnt_dec = cdec_q;
					cmd.cnt_dec2 = dist2_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ev_v_q   <= 1'b0;
			pend_v_q <= 1'b0;
			cinc_q   <= 1'b0;
			cdec_q   <= 1'b0;
			dist2_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			ev_v_q   <= ev_v_d;
			pend_v_q <= pend_v_d;
			cinc_q   <= cinc_d;
			cdec_q   <= cdec_d;
			dist2_q  <= dist2_d;
		end
	end

	always_ff @(posedge clk) begin
		ri_q       <= ri_d;
		lo_q       <= lo_d;
		hit_q      <= hit_d;
		ev_idx_q   <= ev_idx_d;
		pend_dst_q <= pend_dst_d;
		st_q       <= st_d;
	end
endmodule
`default_nettype wire

// ===== rtl/core/best_fit_region_allocator_unit.sv =====
// Top level of the best-fit region allocator.
//  channel  | dir | handshake    | payload
//  req_ch   | in  | valid/ready  | command, owner_id, request_size
//  rsp_ch   | out | valid/ready  | result_status, region_start, region_length
//  cfg      | in  | cfg_we       | cfg_wdata = total_size
// One item at a time. An item scans the table with one table read per cycle,
// then shifts entries when a split or merge moves part of the table, and ends
// with the table writes for the split, merge or plain update.
// After reset or a total_size write, the INIT state rewrites entry 0 before the next item.
// The result waits in an output register; a new item is taken meanwhile, and
// its result is held back until that register is free.
`default_nettype none
module best_fit_region_allocator_unit #(
	parameter int TABLE_DEPTH = bfra_pkg::TABLE_DEPTH_DEF,
	parameter int ADDR_BITS   = bfra_pkg::ADDR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [ADDR_BITS-1:0] cfg_wdata,
	bfra_req_if.sink                  req_ch,
	bfra_rsp_if.source                rsp_ch
);
	import bfra_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1) + 1;

	dp_cmd_t       cmd;
	dp_sts_t       sts;
	logic [AW-1:0] rd_addr, wr_addr, ev_idx, best_idx;
	logic [CW-1:0] count;

	bfra_ctrl #(.AW(AW), .CW(CW)) u_ctrl (
		.clk, .arst_n,
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.sts, .best_idx, .count, .cmd, .rd_addr, .wr_addr, .ev_idx
	);

	bfra_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH), .ADDR_BITS(ADDR_BITS), .AW(AW), .CW(CW)
	) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.req_command (req_ch.command),
		.req_owner   (req_ch.owner_id),
		.req_size    (req_ch.request_size),
		.cmd, .rd_addr, .wr_addr, .ev_idx, .best_idx, .count, .sts,
		.out_ready   (rsp_ch.ready),
		.out_valid   (rsp_ch.valid),
		.out_status  (rsp_ch.result_status),
		.out_start   (rsp_ch.region_start),
		.out_length  (rsp_ch.region_length)
	);
endmodule
`default_nettype wire

// ===== rtl/core/bfra_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
`default_nettype none
module bfra_props #(
	parameter int AB = 20
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          cfg_we,
	input wire logic          in_valid,
	input wire logic          in_ready,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire logic [1:0]    out_status,
	input wire logic [AB-1:0] out_start,
	input wire logic [AB-1:0] out_length
);
	import bfra_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_start) && $stable(out_length))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_OK |-> out_start == '0 && out_length == '0)
		else $error("error result carries a region");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is at work");

	a_cfg_init: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("item taken before table rebuilt");
endmodule

bind best_fit_region_allocator_unit bfra_props #(.AB(ADDR_BITS)) u_bfra_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_we     (cfg_we),
	.in_valid   (req_ch.valid),
	.in_ready   (req_ch.ready),
	.out_valid  (rsp_ch.valid),
	.out_ready  (rsp_ch.ready),
	.out_status (rsp_ch.result_status),
	.out_start  (rsp_ch.region_start),
	.out_length (rsp_ch.region_length)
);
`default_nettype wire

// ===== tb/bfra_checker.sv =====
// Checker for the region allocator: predicts each response and compares it.
`default_nettype none
module bfra_checker #(
	parameter int TABLE_DEPTH = 64,
	parameter int ADDR_BITS   = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [ADDR_BITS-1:0] cfg_wdata,
	bfra_req_if                       req_ch,
	bfra_rsp_if                       rsp_ch,
	output int                        fail_count,
	output int                        pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import bfra_pkg::*;

	typedef struct packed {
		logic [1:0]           status;
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] length;
	} region_rsp_t;

	logic [ADDR_BITS-1:0] mem_size;
	logic [ADDR_BITS-1:0] rg_start [TABLE_DEPTH];
	logic [ADDR_BITS-1:0] rg_len [TABLE_DEPTH];
	logic [15:0]          rg_owner [TABLE_DEPTH];
	logic                 rg_free [TABLE_DEPTH];
	int                   rg_count;
	region_rsp_t          rsp_queue [$];

	assign pending_count = rsp_queue.size();

	function automatic void table_clear();
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			rg_start[k] = '0;
			rg_len[k] = '0;
			rg_owner[k] = '0;
			rg_free[k] = 1'b0;
		end
		rg_len[0] = mem_size;
		rg_free[0] = 1'b1;
		rg_count = (mem_size != 0) ? 1 : 0;
	endfunction

	function automatic void move_entry(int dst, int src);
		rg_start[dst] = rg_start[src];
		rg_len[dst] = rg_len[src];
		rg_owner[dst] = rg_owner[src];
		rg_free[dst] = rg_free[src];
	endfunction

	function automatic void drop_entry(int idx);
		for (int k = idx; k + 1 < rg_count; k++)
			move_entry(k, k + 1);
		rg_count--;
	endfunction

	function automatic region_rsp_t alloc_region(logic [15:0] owner, logic [ADDR_BITS-1:0] req);
		region_rsp_t r;
		int best;
		logic [ADDR_BITS-1:0] best_len;
		logic found;
		r = '0;
		best = 0;
		best_len = '0;
		found = 1'b0;
		if (req == 0) begin
			r.status = ST_NOFIT;
			return r;
		end
		for (int i = 0; i < rg_count; i++)
			if (rg_free[i] && rg_len[i] >= req && (!found || rg_len[i] < best_len)) begin
				found = 1'b1;
				best = i;
				best_len = rg_len[i];
			end
		if (!found) begin
			r.status = ST_NOFIT;
			return r;
		end
		if (best_len > req) begin
			if (rg_count >= TABLE_DEPTH) begin
				r.status = ST_FULL;
				return r;
			end
			for (int k = rg_count; k > best + 1; k--)
				move_entry(k, k - 1);
			rg_start[best+1] = rg_start[best] + req;
			rg_len[best+1] = best_len - req;
			rg_owner[best+1] = '0;
			rg_free[best+1] = 1'b1;
			rg_len[best] = req;
			rg_count++;
		end
		rg_owner[best] = owner;
		rg_free[best] = 1'b0;
		r.status = ST_OK;
		r.start = rg_start[best];
		r.length = rg_len[best];
		return r;
	endfunction

	function automatic region_rsp_t release_region(logic [15:0] owner);
		region_rsp_t r;
		int i;
		r = '0;
		i = 0;
		while (i < rg_count && !(!rg_free[i] && rg_owner[i] == owner))
			i++;
		if (i >= rg_count) begin
			r.status = ST_NOOWNER;
			return r;
		end
		r.status = ST_OK;
		r.start = rg_start[i];
		r.length = rg_len[i];
		rg_free[i] = 1'b1;
		rg_owner[i] = '0;
		if (i > 0 && rg_free[i-1]) begin
			rg_len[i-1] = rg_len[i-1] + rg_len[i];
			drop_entry(i);
			i--;
		end
		if (i + 1 < rg_count && rg_free[i+1]) begin
			rg_len[i] = rg_len[i] + rg_len[i+1];
			drop_entry(i + 1);
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size = {ADDR_BITS{1'b1}};
			table_clear();
			rsp_queue.delete();
			fail_count = 0;
		end else begin
			region_rsp_t got, want;
			if (cfg_we) begin
				mem_size = cfg_wdata;
				table_clear();
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.result_status, rsp_ch.region_start, rsp_ch.region_length};
				if (rsp_queue.size() == 0) begin
					report_mismatch("unexpected item", 1, 0);
				end else begin
					want = rsp_queue.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", got.status, want.status);
					if (got.start !== want.start)
						report_mismatch("start", got.start, want.start);
					if (got.length !== want.length)
						report_mismatch("length", got.length, want.length);
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.command == CMD_ALLOC)
					rsp_queue.push_back(alloc_region(req_ch.owner_id, req_ch.request_size));
				else
					rsp_queue.push_back(release_region(req_ch.owner_id));
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Stimulus and verdict for the best-fit region allocator.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bfra_pkg::*;

	localparam int AB = 20;
	localparam int DEPTH = 64;
	localparam int DRAIN = 2 * DEPTH + 40;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [AB-1:0] cfg_wdata;
	int            fail_count;
	int            pending_count;
	int            send_idle_pct;
	int            recv_idle_pct;
	logic          hold_rsp;
	logic [15:0]   owners [$];

	bfra_req_if #(.AB(AB)) req_ch ();
	bfra_rsp_if #(.AB(AB)) rsp_ch ();

	best_fit_region_allocator_unit #(.TABLE_DEPTH(DEPTH), .ADDR_BITS(AB)) i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_ch(req_ch), .rsp_ch(rsp_ch)
	);

	bfra_checker #(.TABLE_DEPTH(DEPTH), .ADDR_BITS(AB)) i_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_ch(req_ch), .rsp_ch(rsp_ch),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("*** FAILED ***");
		$finish;
	end

	// response side idling, with an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
	end

	// one item, with a random gap before it; valid drops only in a gap or at idle
	task automatic send_item(logic cmd, logic [15:0] owner, logic [AB-1:0] size);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.owner_id <= owner;
		req_ch.request_size <= size;
		do @(posedge clk); while (!req_ch.ready);
		if (cmd == CMD_ALLOC)
			owners.push_back(owner);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_size(logic [AB-1:0] size);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
		owners.delete();
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_owner();
		if (owners.size() != 0 && $urandom_range(9) < 8)
			return owners[$urandom_range(owners.size() - 1)];
		return 16'($urandom_range(15));
	endfunction

	task automatic random_items(int n, logic [AB-1:0] size_cap);
		logic [AB-1:0] sz;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: sz = AB'($urandom);
				1: sz = '0;
				default: sz = AB'($urandom_range(size_cap));
			endcase
			if ($urandom_range(1) == 0)
				send_item(CMD_ALLOC, ($urandom_range(7) == 0) ? 16'($urandom) :
					16'($urandom_range(15)), sz);
			else
				send_item(CMD_RELEASE, pick_owner(), AB'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_rsp = 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 66;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_ALLOC;
		req_ch.owner_id = '0;
		req_ch.request_size = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: extremes, zero request, exact fit, unknown owner, merges
		send_item(CMD_ALLOC, 16'hFFFF, '0);
		send_item(CMD_ALLOC, 16'hFFFF, 20'hFFFFF);
		send_item(CMD_RELEASE, 16'h0000, '0);
		send_item(CMD_RELEASE, 16'hFFFF, 20'hFFFFF);
		send_item(CMD_ALLOC, 16'h0001, 20'h00001);
		send_item(CMD_ALLOC, 16'h0002, 20'h00010);
		send_item(CMD_ALLOC, 16'h0003, 20'h00100);
		send_item(CMD_RELEASE, 16'h0002, '0);
		send_item(CMD_RELEASE, 16'h0001, '0);
		send_item(CMD_RELEASE, 16'h0003, '0);
		send_item(CMD_RELEASE, 16'h0003, '0);
		set_size('0);
		send_item(CMD_ALLOC, 16'h0005, 20'h00001);
		send_item(CMD_RELEASE, 16'h0005, '0);
		set_size(20'd1);
		send_item(CMD_ALLOC, 16'h0007, 20'd2);
		send_item(CMD_ALLOC, 16'h0007, 20'd1);
		send_item(CMD_ALLOC, 16'h0008, 20'd1);
		send_item(CMD_RELEASE, 16'h0007, '0);
		// table full: 63 unit allocations leave one free tail, then a split fails
		set_size(20'd200);
		for (int k = 0; k < 63; k++)
			send_item(CMD_ALLOC, 16'(k), 20'd1);
		send_item(CMD_ALLOC, 16'h0100, 20'd5);
		send_item(CMD_ALLOC, 16'h0101, 20'd137);
		send_item(CMD_RELEASE, 16'd10, '0);
		send_item(CMD_ALLOC, 16'h0102, 20'd1);

		// long receiver hold-off while the sender keeps offering items
		set_size(20'd5000);
		hold_rsp = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_rsp = 1'b0;
			end
			random_items(20, 20'd400);
		join

		set_size(20'd4096);
		random_items(500, 20'd300);
		send_idle_pct = 66;
		recv_idle_pct = 16;
		set_size(20'hFFFFF);
		random_items(450, 20'd60000);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_size(20'd700);
		random_items(450, 20'd40);

		wait_idle();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/bfra_pkg.sv
rtl/core/bfra_if.sv
rtl/core/bfra_datapath.sv
rtl/core/bfra_ctrl.sv
rtl/core/best_fit_region_allocator_unit.sv
rtl/core/bfra_checker.sv
tb/bfra_checker.sv
tb/testbench.sv
